[hdl/lpr_pkg.sv]
package lpr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_WIDTH = 16;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NUM_W      = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W     = IDX_W;
    localparam int RANK_MAX   = MAX_FRAMES - 1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

    // controller -> datapath
    typedef struct packed {
        logic init;     // load reference, clear scan state
        logic scan;     // walk frames through the compare
        logic evrd;     // read victim page
        logic update;   // commit and emit result
    } lpr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic found;
        logic have_empty;
    } lpr_sts_t;

endpackage

[hdl/lpr_ram.sv]
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/lpr_ctrl.sv]
module lpr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lpr_pkg::lpr_sts_t sts,
    output lpr_pkg::lpr_cmd_t cmd,
    output logic              busy
);
    import lpr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_EVRD   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.found || sts.have_empty)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_EVRD;
                end
            end
            S_EVRD:
            begin
                cmd.evrd   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hdl/lpr_dp.sv]
module lpr_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpr_pkg::lpr_cmd_t            cmd,
    output lpr_pkg::lpr_sts_t            sts,
    input  logic [lpr_pkg::NUM_W-1:0]    n_frames,
    input  logic [lpr_pkg::PAGE_WIDTH-1:0] page_number,
    output logic                         done,
    output logic                         hit,
    output logic [lpr_pkg::IDX_W-1:0]    frame_slot,
    output logic                         evicted_valid,
    output logic [lpr_pkg::PAGE_WIDTH-1:0] evicted_page,
    output logic [lpr_pkg::CNT_W-1:0]    fault_total
);
    import lpr_pkg::*;

    logic [PAGE_WIDTH-1:0] page_reg;
    logic [NUM_W-1:0]      issue_reg, issue_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_slot_reg, hit_slot_next;
    logic                  empty_reg, empty_next;
    logic [IDX_W-1:0]      empty_slot_reg, empty_slot_next;
    logic [RANK_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]      lru_slot_reg, lru_slot_next;
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]     rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_next [MAX_FRAMES];
    logic [CNT_W-1:0]      fault_reg, fault_next;
    logic                  done_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      slot_out_reg;
    logic                  ev_valid_reg;
    logic [PAGE_WIDTH-1:0] ev_page_reg;
    logic [CNT_W-1:0]      total_reg;

    logic [IDX_W-1:0]      issue_idx;
    logic                  issuing;
    logic [IDX_W-1:0]      slot;
    logic                  evict;
    logic [RANK_W-1:0]     hit_rank;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [PAGE_WIDTH-1:0] ram_rdata;

    assign issue_idx = issue_reg[IDX_W-1:0];
    assign issuing   = cmd.scan && (issue_reg < n_frames);
    assign ram_re    = issuing || cmd.evrd;
    assign ram_raddr = cmd.evrd ? lru_slot_reg : issue_idx;

    assign slot     = found_reg ? hit_slot_reg : (empty_reg ? empty_slot_reg : lru_slot_reg);
    assign evict    = !found_reg && !empty_reg;
    assign hit_rank = rank_reg[slot];

    assign sts.scan_last  = (issue_reg == n_frames);
    assign sts.found      = found_reg;
    assign sts.have_empty = empty_reg;

    lpr_ram #(
        .WIDTH (PAGE_WIDTH),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (slot),
        .wdata (page_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan: issue one read per cycle, compare the previous read
    always_comb
    begin
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        hit_slot_next   = hit_slot_reg;
        empty_next      = empty_reg;
        empty_slot_next = empty_slot_reg;
        best_next       = best_reg;
        lru_slot_next   = lru_slot_reg;
        if (cmd.init)
        begin
            issue_next = '0;
            found_next = 1'b0;
            empty_next = 1'b0;
        end
        else
        begin
            if (issuing)
            begin
                issue_next   = issue_reg + NUM_W'(1);
                chk_vld_next = 1'b1;
                chk_idx_next = issue_idx;
                if (!valid_reg[issue_idx] && !empty_reg)
                begin
                    empty_next      = 1'b1;
                    empty_slot_next = issue_idx;
                end
                // strict greater keeps the lowest index on a tie
                if ((issue_reg == '0) || (rank_reg[issue_idx] > best_reg))
                begin
                    best_next     = rank_reg[issue_idx];
                    lru_slot_next = issue_idx;
                end
            end
            if (chk_vld_reg && !found_reg && valid_reg[chk_idx_reg]
                && (ram_rdata == page_reg))
            begin
                found_next    = 1'b1;
                hit_slot_next = chk_idx_reg;
            end
        end
    end

    // commit: ranks, valid bits, fault count
    always_comb
    begin
        valid_next = valid_reg;
        fault_next = fault_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.update)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                if ((NUM_W'(i) < n_frames) && (IDX_W'(i) != slot) && valid_reg[i]
                    && (!found_reg || (rank_reg[i] < hit_rank))
                    && (rank_reg[i] != RANK_W'(RANK_MAX)))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            rank_next[slot]  = '0;
            valid_next[slot] = 1'b1;
            if (!found_reg && (fault_reg != '1))
            begin
                fault_next = fault_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            empty_reg   <= 1'b0;
            valid_reg   <= '0;
            fault_reg   <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            empty_reg   <= empty_next;
            valid_reg   <= valid_next;
            fault_reg   <= fault_next;
            done_reg    <= cmd.update;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        hit_slot_reg   <= hit_slot_next;
        empty_slot_reg <= empty_slot_next;
        best_reg       <= best_next;
        lru_slot_reg   <= lru_slot_next;
        if (cmd.init)
        begin
            page_reg <= page_number;
        end
        if (cmd.update)
        begin
            hit_reg      <= found_reg;
            slot_out_reg <= slot;
            ev_valid_reg <= evict;
            ev_page_reg  <= evict ? ram_rdata : '0;
            total_reg    <= fault_next;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = total_reg;

endmodule

[hdl/lru_page_replacement.sv]
// LRU page replacement, one page reference per transfer.
// A hit or fill runs scan, decide and commit; an eviction adds a victim read
//   before the commit. The scan covers n frames (n = frames in use, 1..8).
// References are taken only while idle; the single page compare walks the frame
//   RAM one entry per cycle. Results cannot be stalled (done strobe).
// Reset (async, rst_n low): frames empty, ranks and fault count zero, frames_in_use = 3.
module lru_page_replacement (
    input  logic                           clk,
    input  logic                           rst_n,
    // reference channel
    input  logic                           start,
    output logic                           busy,
    input  logic [lpr_pkg::PAGE_WIDTH-1:0] page_number,
    // result channel
    output logic                           done,
    output logic                           hit,
    output logic [lpr_pkg::IDX_W-1:0]      frame_slot,
    output logic                           evicted_valid,
    output logic [lpr_pkg::PAGE_WIDTH-1:0] evicted_page,
    output logic [lpr_pkg::CNT_W-1:0]      fault_total,
    // frames_in_use register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]      cfg_data
);
    import lpr_pkg::*;

    logic [CFG_W-1:0] frames_reg;
    logic [NUM_W-1:0] n_frames;
    lpr_cmd_t         cmd;
    lpr_sts_t         sts;

    // Config is only taken between references, so the scan never sees it move.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_reg <= cfg_data;
        end
    end

    // Zero acts as one frame, anything above the table size as the full table.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_frames = NUM_W'(1);
        end
        else if (32'(frames_reg) > MAX_FRAMES)
        begin
            n_frames = NUM_W'(MAX_FRAMES);
        end
        else
        begin
            n_frames = NUM_W'(frames_reg);
        end
    end

    // Controller sequences scan -> decide -> (victim read) -> commit.
    lpr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: page RAM, valid bits, recency ranks, fault counter, result regs.
    lpr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .n_frames      (n_frames),
        .page_number   (page_number),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("done strobe outside end of a reference");

    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> !hit)
        else $error("eviction reported on a hit");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (fault_total != '0))
        else $error("fault not counted");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(frame_slot) < 32'(n_frames)))
        else $error("result slot outside frames in use");
`endif

endmodule

[verif/tb_lru_page_replacement.sv]
module tb_lru_page_replacement;

    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    // Cycles without any transfer (reference, result or register write)
    // before the run is declared hung. The slowest legal item is a sender gap
    // plus the work of one reference with an eviction, so this is far above that.
    localparam int HANG_LIMIT = 1000;

    // One expected result per accepted reference.
    typedef struct {
        logic                  hit;
        logic [IDX_W-1:0]      slot;
        logic                  ev_valid;
        logic [PAGE_WIDTH-1:0] ev_page;
        logic [CNT_W-1:0]      total;
    } ref_outcome_t;

    // LRU predictor and result store. Keeps its own copy of the frame table,
    // ages and fault count, plus the frames_in_use register.
    class lru_scoreboard;
        logic [CFG_W-1:0]      frames_in_use;
        logic [PAGE_WIDTH-1:0] page_held [MAX_FRAMES];
        logic                  frame_used [MAX_FRAMES];
        logic [RANK_W-1:0]     age_rank [MAX_FRAMES];
        logic [CNT_W-1:0]      faults;
        ref_outcome_t          outcomes [$];
        int                    errors;

        function new();
            frames_in_use = CFG_RESET;
            foreach (page_held[i])
            begin
                page_held[i]  = '0;
                frame_used[i] = 1'b0;
                age_rank[i]   = '0;
            end
            faults = '0;
            errors = 0;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function void set_frames(input logic [CFG_W-1:0] value);
            frames_in_use = value;
        endfunction

        // Ages saturate at the oldest rank.
        function void grow_older(input int i);
            if (age_rank[i] < RANK_MAX)
                age_rank[i] = age_rank[i] + 1'b1;
        endfunction

        // Applies one accepted reference and queues the result it causes.
        function void note_reference(input logic [PAGE_WIDTH-1:0] pg);
            ref_outcome_t      r;
            int                n;
            int                slot;
            bit                found;
            bit                have_empty;
            logic [RANK_W-1:0] top;

            // 0 acts as one frame, anything above the table as all of it
            n = frames_in_use;
            if (n < 1)
                n = 1;
            if (n > MAX_FRAMES)
                n = MAX_FRAMES;

            r          = '{default: '0};
            slot       = 0;
            found      = 1'b0;
            have_empty = 1'b0;

            // lowest-index match wins when a page sits in two frames
            for (int i = 0; i < n; i++)
                if (!found && frame_used[i] && page_held[i] == pg)
                begin
                    slot  = i;
                    found = 1'b1;
                end

            if (found)
            begin
                // only frames younger than the hit one move back
                top = age_rank[slot];
                for (int i = 0; i < n; i++)
                    if (i != slot && frame_used[i] && age_rank[i] < top)
                        grow_older(i);
                age_rank[slot] = '0;
                r.hit = 1'b1;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    if (!have_empty && !frame_used[i])
                    begin
                        slot       = i;
                        have_empty = 1'b1;
                    end
                if (!have_empty)
                begin
                    // oldest frame goes, strict compare keeps the lowest index on a tie
                    slot = 0;
                    top  = age_rank[0];
                    for (int i = 1; i < n; i++)
                        if (age_rank[i] > top)
                        begin
                            top  = age_rank[i];
                            slot = i;
                        end
                    r.ev_valid = 1'b1;
                    r.ev_page  = page_held[slot];
                end
                for (int i = 0; i < n; i++)
                    if (i != slot && frame_used[i])
                        grow_older(i);
                page_held[slot]  = pg;
                frame_used[slot] = 1'b1;
                age_rank[slot]   = '0;
                if (faults != '1)
                    faults = faults + 1'b1;
            end

            r.slot  = slot;
            r.total = faults;
            outcomes.push_back(r);
        endfunction

        function void check_result(input ref_outcome_t got);
            ref_outcome_t want;
            if (outcomes.size() == 0)
            begin
                $display("%0t: result with nothing expected (slot %0d, hit %0b)",
                         $time, got.slot, got.hit);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit mismatch, expected %0b, got %0b",
                         $time, want.hit, got.hit);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $display("%0t: frame_slot mismatch, expected %0d, got %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
            if (got.ev_valid !== want.ev_valid)
            begin
                $display("%0t: evicted_valid mismatch, expected %0b, got %0b",
                         $time, want.ev_valid, got.ev_valid);
                errors++;
            end
            if (got.ev_page !== want.ev_page)
            begin
                $display("%0t: evicted_page mismatch, expected %h, got %h",
                         $time, want.ev_page, got.ev_page);
                errors++;
            end
            if (got.total !== want.total)
            begin
                $display("%0t: fault_total mismatch, expected %0d, got %0d",
                         $time, want.total, got.total);
                errors++;
            end
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [PAGE_WIDTH-1:0] page_number = '0;
    logic                  done;
    logic                  hit;
    logic [IDX_W-1:0]      frame_slot;
    logic                  evicted_valid;
    logic [PAGE_WIDTH-1:0] evicted_page;
    logic [CNT_W-1:0]      fault_total;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data    = '0;

    lru_scoreboard sb = new();

    // when set, the sender drives references back to back
    bit no_gaps = 1'b0;
    int idle_cycles = 0;

    // page pool for the random phases; small pools give hits and evictions
    logic [PAGE_WIDTH-1:0] pool [12];
    int                    pool_size = 1;

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates land, so each transfer is seen exactly as the block takes it.
    always @(posedge clk)
    begin
        ref_outcome_t got;
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_reference(page_number);
            if (cfg_valid && cfg_ready)
                sb.set_frames(cfg_data);
            if (done)
            begin
                got.hit      = hit;
                got.slot     = frame_slot;
                got.ev_valid = evicted_valid;
                got.ev_page  = evicted_page;
                got.total    = fault_total;
                sb.check_result(got);
            end
        end

        // hang detection
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One reference transfer. start stays high on return so a following
    // zero-gap reference goes out without a bubble.
    task automatic send_ref(input logic [PAGE_WIDTH-1:0] pg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        page_number <= pg;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait out every outstanding result. The first edge
    // lets the monitor record a reference taken at the current edge.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Register write, only with the block idle.
    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PAGE_WIDTH-1:0] pick_page();
        case ($urandom_range(0, 9))
            0:       return PAGE_WIDTH'($urandom);
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return pool[$urandom_range(0, pool_size - 1)];
        endcase
    endfunction

    initial
    begin
        // frames_in_use values of the random phases, out-of-range ones included
        logic [CFG_W-1:0] phase_frames [12] = '{8, 2, 15, 1, 6, 0, 4, 8, 7, 5, 3, 9};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting of three frames. Fill, hit, then evictions
        // of the oldest frame, all-zero and all-one pages.
        send_ref(16'h0000);
        send_ref(16'hFFFF);
        send_ref(16'h0000);
        send_ref(16'h1234);
        send_ref(16'hFFFF);
        send_ref(16'h5555);
        send_ref(16'h0000);
        send_ref(16'hAAAA);
        send_ref(16'h1234);

        // zero acts as a single frame: every miss evicts frame 0
        write_frames_in_use(4'd0);
        send_ref(16'h0001);
        send_ref(16'h0001);
        send_ref(16'hFFFF);

        // above the table acts as all eight; hidden frames come back,
        // their old pages and ages with them
        write_frames_in_use(4'd15);
        send_ref(16'h0001);
        send_ref(16'hAAAA);
        send_ref(16'hFFFF);
        send_ref(16'h7777);
        send_ref(16'h8888);
        send_ref(16'h9999);
        send_ref(16'h4321);
        send_ref(16'hBEEF);
        send_ref(16'h0001);

        // shrink: upper frames are frozen, not searched
        write_frames_in_use(4'd2);
        send_ref(16'hBEEF);
        send_ref(16'h0001);
        send_ref(16'h1357);

        // Random phases, each with its own setting, pool and idling style.
        for (int p = 0; p < 12; p++)
        begin
            write_frames_in_use(phase_frames[p]);
            pool_size = $urandom_range(1, 12);
            foreach (pool[i])
                pool[i] = PAGE_WIDTH'($urandom);
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < 65; k++)
            begin
                // one hold-off in the middle until everything has come back
                if (p == 3 && k == 32)
                    wait_for_results();
                send_ref(pick_page());
            end
        end
        no_gaps = 1'b0;

        wait_for_results();
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[lru_page_replacement.f]
hdl/lpr_pkg.sv
hdl/lpr_ram.sv
hdl/lpr_ctrl.sv
hdl/lpr_dp.sv
hdl/lru_page_replacement.sv
verif/tb_lru_page_replacement.sv
